@@ hw/rtl/i2cms_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Command codes, line constants and the item types shared by the modules.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam int unsigned OpW      = 3;
  localparam int unsigned PhaseW   = 5;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  localparam logic [OpW-1:0] OP_START = 3'd0;
  localparam logic [OpW-1:0] OP_STOP  = 3'd1;
  localparam logic [OpW-1:0] OP_WRITE = 3'd2;
  localparam logic [OpW-1:0] OP_WAIT  = 3'd3;
  localparam logic [OpW-1:0] OP_READ  = 3'd4;
  localparam logic [OpW-1:0] OP_IDLE  = 3'd7;

  localparam logic [ByteW-1:0] MSB_MASK = 8'h80;

  // Last phase of a byte transfer on the bus (eight bits, two phases each).
  localparam logic [PhaseW-1:0] PHASE_BYTE_LAST = 5'd15;

  typedef struct packed {
    logic             sda_in;
    logic             send_ack;
    logic [ByteW-1:0] write_data;
    logic [OpW-1:0]   opcode;
    logic             cmd_valid;
  } in_item_t;

  typedef struct packed {
    logic             ack_missing;
    logic [ByteW-1:0] read_byte;
    logic             done_res;
    logic             busy_res;
    logic             sda_release;
    logic             scl_out;
  } out_item_t;

endpackage
`default_nettype wire

@@ hw/rtl/i2c_master_bit_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Each input transaction is registered, its bus phase is worked out
// combinationally and the result is held in the result register until taken.
// Throughput: one transaction per cycle while the output is not stalled; each
// item is at most one bus phase, the phase logic between registers one step.
// Reset: asynchronous, active low; the sequencer goes idle with SCL and SDA
// released high and both stream registers empty.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [0] cmd_valid, [3:1] opcode, [11:4] write_data, [12] send_ack,
  // [13] sda_in, [15:14] ignored
  input  wire  [i2cms_pkg::InDataW-1:0]       s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  wire                                 m_axis_tready_i,
  // [0] scl_out, [1] sda_release, [2] busy_res, [3] done_res,
  // [11:4] read_byte, [12] ack_missing, [15:13] zero
  output logic [i2cms_pkg::OutDataW-1:0]      m_axis_tdata_o
);
  import i2cms_pkg::*;

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t res;
  logic      step;

  // The core advances whenever the input register holds an item and the
  // result register is empty or being drained.
  assign step            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q <= in_item_t'(s_axis_tdata_i[$bits(in_item_t)-1:0]);
    end
  end

  i2cms_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_item_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - $bits(out_item_t)){1'b0}}, out_item_q};

endmodule
`default_nettype wire

@@ hw/rtl/i2cms_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master sequencer core
// Holds the command state and works out one bus phase per registered item.
// ----------------------------------------------------------------------------
module i2cms_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  step_i,
  input  i2cms_pkg::in_item_t  item_i,
  output i2cms_pkg::out_item_t res_o
);
  import i2cms_pkg::*;

  logic [OpW-1:0]    cmd_q, cmd_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [ByteW-1:0]  shift_q, shift_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              ack_q, ack_d;
  logic              nack_q, nack_d;

  always_comb begin
    logic [OpW-1:0]    act;
    logic [PhaseW-1:0] p;
    logic              c;
    logic              s;
    logic              done;
    logic              run;

    act     = cmd_q;
    p       = phase_q;
    c       = scl_q;
    s       = sda_q;
    done    = 1'b0;
    run     = 1'b1;
    shift_d = shift_q;
    ack_d   = ack_q;
    nack_d  = nack_q;
    cmd_d   = cmd_q;
    phase_d = phase_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    res_o   = '0;

    if (cmd_q == OP_IDLE) begin
      if (item_i.cmd_valid && (item_i.opcode <= OP_READ)) begin
        act = item_i.opcode;
        p   = '0;
        if (item_i.opcode == OP_WRITE) begin
          shift_d = item_i.write_data;
        end
        if (item_i.opcode == OP_READ) begin
          shift_d = '0;
          ack_d   = item_i.send_ack;
        end
      end else begin
        run = 1'b0;
      end
    end

    if (run) begin
      case (act)
        OP_START: begin
          if (p == 5'd0) begin
            s = 1'b1; c = 1'b1;
          end else if (p == 5'd1) begin
            s = 1'b0; c = 1'b1;
          end else begin
            s = 1'b0; c = 1'b0; done = 1'b1;
          end
        end
        OP_STOP: begin
          if (p == 5'd0) begin
            s = 1'b0;
          end else if (p == 5'd1) begin
            s = 1'b0; c = 1'b1;
          end else begin
            s = 1'b1; c = 1'b1; done = 1'b1;
          end
        end
        OP_WRITE: begin
          s = |(shift_d & MSB_MASK);
          if (p[0]) begin
            c       = 1'b1;
            shift_d = {shift_d[ByteW-2:0], 1'b0};
            done    = (p >= PHASE_BYTE_LAST);
          end
        end
        OP_WAIT: begin
          if (p == 5'd0) begin
            s = 1'b1;
          end else if (p == 5'd1) begin
            s = 1'b1; c = 1'b1; nack_d = item_i.sda_in;
          end else if (p == 5'd2) begin
            // A nack turns the tail of this command into a stop condition.
            if (nack_q) begin
              s = 1'b0; c = 1'b1;
            end else begin
              s = 1'b1; c = 1'b0; done = 1'b1;
            end
          end else if (p == 5'd3) begin
            s = 1'b0; c = 1'b1;
          end else begin
            s = 1'b1; c = 1'b1; done = 1'b1;
          end
          res_o.ack_missing = done & nack_d;
        end
        default: begin
          if (!p[PhaseW-1]) begin
            s = 1'b1;
            if (!p[0]) begin
              c       = 1'b1;
              shift_d = {shift_d[ByteW-2:0], item_i.sda_in};
            end else begin
              c = 1'b0;
            end
          end else if (p == 5'd16) begin
            s = 1'b1; c = 1'b0;
          end else if (p == 5'd17) begin
            s = ~ack_d; c = 1'b0;
          end else begin
            s = ~ack_d; c = 1'b1; done = 1'b1;
          end
          if (done) begin
            res_o.read_byte = shift_d;
          end
        end
      endcase

      scl_d = c;
      sda_d = s;
      // During a write the clock is pulled low again after each high phase,
      // and the data line is released once the byte has gone out.
      if (act == OP_WRITE) begin
        if (p[0]) begin
          scl_d = 1'b0;
        end
        if (done) begin
          sda_d = 1'b1;
        end
      end

      cmd_d   = done ? OP_IDLE : act;
      phase_d = done ? '0 : p + 5'd1;

      res_o.scl_out     = c;
      res_o.sda_release = s;
      res_o.busy_res    = 1'b1;
      res_o.done_res    = done;
    end else begin
      res_o.scl_out     = scl_q;
      res_o.sda_release = sda_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= OP_IDLE;
      phase_q <= '0;
      shift_q <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      ack_q   <= 1'b0;
      nack_q  <= 1'b0;
    end else if (step_i) begin
      cmd_q   <= cmd_d;
      phase_q <= phase_d;
      shift_q <= shift_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      ack_q   <= ack_d;
      nack_q  <= nack_d;
    end
  end

endmodule
`default_nettype wire
